// ===== hdl/i2crm_pkg.sv =====
// i2crm_pkg: shared types and constants for the i2c register transfer master
// item structs, register indexes, phase codes and step state
// no dependencies
`default_nettype none

package i2crm_pkg;

  localparam int MAX_BYTES = 7;

  localparam int DEV_ADDR_W  = 7;
  localparam int ATT_LIM_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd104;
  localparam logic [ATT_LIM_W-1:0]  ATT_LIM_RST  = 3'd3;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_DEV_ADDR  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATT_LIMIT = 1'b1;

  // bus sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_START1    = 4'd1;
  localparam logic [3:0] PH_TX_DEVW   = 4'd2;
  localparam logic [3:0] PH_ACK_DEVW  = 4'd3;
  localparam logic [3:0] PH_TX_REG    = 4'd4;
  localparam logic [3:0] PH_ACK_REG   = 4'd5;
  localparam logic [3:0] PH_TX_DATA   = 4'd6;
  localparam logic [3:0] PH_ACK_DATA  = 4'd7;
  localparam logic [3:0] PH_MIDSTOP   = 4'd8;
  localparam logic [3:0] PH_START2    = 4'd9;
  localparam logic [3:0] PH_TX_DEVR   = 4'd10;
  localparam logic [3:0] PH_ACK_DEVR  = 4'd11;
  localparam logic [3:0] PH_RX_DATA   = 4'd12;
  localparam logic [3:0] PH_MACK      = 4'd13;
  localparam logic [3:0] PH_STOP_OK   = 4'd14;
  localparam logic [3:0] PH_STOP_FAIL = 4'd15;

  typedef struct packed {
    logic        kind;
    logic        is_read;
    logic [7:0]  reg_addr;
    logic [2:0]  byte_count;
    logic [55:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [55:0] read_data;
    logic [2:0]  attempts_used;
  } out_item_t;

  // bus sequencer state, cleared by reset
  typedef struct packed {
    logic [3:0]  phase;
    logic [1:0]  tick;
    logic [2:0]  bit_idx;
    logic [2:0]  byte_idx;
    logic [7:0]  shift;
    logic [2:0]  attempts;
    logic        scl;
    logic        sda;
    logic [55:0] read_buf;
  } seq_state_t;

  // transaction command, held from the command item on
  typedef struct packed {
    logic        is_read;
    logic [7:0]  reg_addr;
    logic [2:0]  byte_count;
    logic [55:0] write_data;
  } cmd_latch_t;

endpackage

`default_nettype wire

// ===== hdl/i2c_register_transfer_master.sv =====
// the accepting edge loads the input register; once the result register is free, a later
// edge loads the result register from it and raises out_valid;
// one item per cycle sustained while out_ready holds, each item one bus tick or one command
// reset (rst_n low, synchronous): bus idle with both lines released, counters
// and read buffer cleared, device_address 104, attempt_limit 3
// i2c_register_transfer_master: top level, depends on i2crm_pkg and i2crm_step
`default_nettype none

module i2c_register_transfer_master (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  i2crm_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output i2crm_pkg::out_item_t                 out_item,
  input  logic                                 cfg_we,
  input  logic [i2crm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [i2crm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import i2crm_pkg::*;

  logic [DEV_ADDR_W-1:0] dev_addr_r;
  logic [ATT_LIM_W-1:0]  att_limit_r;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  seq_state_t state_r;
  seq_state_t state_nxt;
  cmd_latch_t latch_r;
  cmd_latch_t latch_nxt;
  out_item_t  result;

  logic out_free;
  logic step;

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  i2crm_step u_step (
    .state_i     (state_r),
    .latch_i     (latch_r),
    .item_i      (in_item_r),
    .dev_addr_i  (dev_addr_r),
    .att_limit_i (att_limit_r),
    .state_o     (state_nxt),
    .latch_o     (latch_nxt),
    .result_o    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      att_limit_r <= ATT_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:  dev_addr_r  <= cfg_wdata[DEV_ADDR_W-1:0];
        CFG_ATT_LIMIT: att_limit_r <= cfg_wdata[ATT_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_IDLE, tick: 2'd0, bit_idx: 3'd0, byte_idx: 3'd0,
                       shift: 8'h00, attempts: 3'd0, scl: 1'b1, sda: 1'b1,
                       read_buf: '0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    if (step) begin
      out_item_r <= result;
      latch_r    <= latch_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hdl/i2crm_step.sv =====
// i2crm_step: next-state and result logic for one item of the i2c master
// purely combinational, sits between the input register and result register
// depends on i2crm_pkg
`default_nettype none

module i2crm_step (
  input  i2crm_pkg::seq_state_t          state_i,
  input  i2crm_pkg::cmd_latch_t          latch_i,
  input  i2crm_pkg::in_item_t            item_i,
  input  logic [i2crm_pkg::DEV_ADDR_W-1:0] dev_addr_i,
  input  logic [i2crm_pkg::ATT_LIM_W-1:0]  att_limit_i,
  output i2crm_pkg::seq_state_t          state_o,
  output i2crm_pkg::cmd_latch_t          latch_o,
  output i2crm_pkg::out_item_t           result_o
);
  import i2crm_pkg::*;

  seq_state_t s;
  cmd_latch_t l;
  logic       done;
  logic       ok;
  logic       nack;
  logic [2:0] cnt;
  logic [2:0] byte_n;
  logic [2:0] att_n;
  logic [7:0] rx_byte;
  logic [1:0] t;

  always_comb begin
    s       = state_i;
    l       = latch_i;
    done    = 1'b0;
    ok      = 1'b0;
    nack    = 1'b0;
    cnt     = item_i.byte_count;
    byte_n  = state_i.byte_idx + 3'd1;
    att_n   = (state_i.attempts == 3'd7) ? 3'd7 : state_i.attempts + 3'd1;
    rx_byte = {state_i.shift[6:0], item_i.sda_in};
    t       = state_i.tick;

    if (item_i.kind) begin
      // a command while busy is dropped
      if (state_i.phase == PH_IDLE) begin
        if (cnt == 3'd0) cnt = 3'd1;
        if (cnt > 3'(MAX_BYTES)) cnt = 3'(MAX_BYTES);
        l.is_read    = item_i.is_read;
        l.reg_addr   = item_i.reg_addr;
        l.byte_count = cnt;
        l.write_data = item_i.write_data;
        s.phase      = PH_START1;
        s.tick       = 2'd0;
        s.bit_idx    = 3'd0;
        s.byte_idx   = 3'd0;
        s.attempts   = 3'd0;
        s.read_buf   = '0;
        s.scl        = 1'b1;
        s.sda        = 1'b1;
      end
    end else if (state_i.phase == PH_IDLE) begin
      s.scl = 1'b1;
      s.sda = 1'b1;
    end else begin
      // line levels for this tick of the slot
      if (state_i.phase inside {PH_START1, PH_START2}) begin
        s.scl = (t < 2'd2);
        s.sda = (t == 2'd0);
      end else if (state_i.phase inside {PH_MIDSTOP, PH_STOP_OK, PH_STOP_FAIL}) begin
        s.scl = (t >= 2'd1);
        s.sda = (t >= 2'd2);
      end else begin
        s.scl = (t == 2'd1);
        if (state_i.phase inside {PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR}) begin
          s.sda = state_i.shift[7];
        end else if (state_i.phase == PH_MACK) begin
          // nack after the last byte
          s.sda = ({1'b0, state_i.byte_idx} + 4'd1) >= {1'b0, latch_i.byte_count};
        end else begin
          s.sda = 1'b1;
        end
      end

      if (t < 2'd2) begin
        s.tick = t + 2'd1;
      end else begin
        s.tick = 2'd0;
        case (state_i.phase)
          PH_START1: begin
            s.phase   = PH_TX_DEVW;
            s.shift   = {dev_addr_i, 1'b0};
            s.bit_idx = 3'd0;
          end
          PH_START2: begin
            s.phase   = PH_TX_DEVR;
            s.shift   = {dev_addr_i, 1'b1};
            s.bit_idx = 3'd0;
          end
          PH_MIDSTOP: begin
            s.phase = PH_START2;
          end
          PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
            s.shift = {state_i.shift[6:0], 1'b0};
            if (state_i.bit_idx == 3'd7) begin
              s.bit_idx = 3'd0;
              s.phase   = state_i.phase + 4'd1;
            end else begin
              s.bit_idx = state_i.bit_idx + 3'd1;
            end
          end
          PH_ACK_DEVW: begin
            if (item_i.sda_in) begin
              nack = 1'b1;
            end else begin
              s.phase   = PH_TX_REG;
              s.shift   = latch_i.reg_addr;
              s.bit_idx = 3'd0;
            end
          end
          PH_ACK_REG: begin
            if (item_i.sda_in) begin
              nack = 1'b1;
            end else if (latch_i.is_read) begin
              s.phase = PH_MIDSTOP;
            end else begin
              s.byte_idx = 3'd0;
              s.phase    = PH_TX_DATA;
              s.shift    = latch_i.write_data[7:0];
              s.bit_idx  = 3'd0;
            end
          end
          PH_ACK_DATA: begin
            if (item_i.sda_in) begin
              nack = 1'b1;
            end else begin
              s.byte_idx = byte_n;
              if (byte_n >= latch_i.byte_count) begin
                s.phase = PH_STOP_OK;
              end else begin
                s.phase   = PH_TX_DATA;
                s.shift   = 8'(latch_i.write_data >> {byte_n, 3'b000});
                s.bit_idx = 3'd0;
              end
            end
          end
          PH_ACK_DEVR: begin
            if (item_i.sda_in) begin
              nack = 1'b1;
            end else begin
              s.byte_idx = 3'd0;
              s.phase    = PH_RX_DATA;
              s.shift    = 8'h00;
              s.bit_idx  = 3'd0;
            end
          end
          PH_RX_DATA: begin
            s.shift = rx_byte;
            if (state_i.bit_idx == 3'd7) begin
              s.bit_idx = 3'd0;
              if (state_i.byte_idx < 3'(MAX_BYTES)) begin
                s.read_buf = state_i.read_buf
                           | (56'(rx_byte) << {state_i.byte_idx, 3'b000});
              end
              s.phase = PH_MACK;
            end else begin
              s.bit_idx = state_i.bit_idx + 3'd1;
            end
          end
          PH_MACK: begin
            s.byte_idx = byte_n;
            if (byte_n >= latch_i.byte_count) begin
              s.phase = PH_STOP_OK;
            end else begin
              s.phase   = PH_RX_DATA;
              s.shift   = 8'h00;
              s.bit_idx = 3'd0;
            end
          end
          PH_STOP_OK: begin
            done    = 1'b1;
            ok      = 1'b1;
            s.phase = PH_IDLE;
          end
          default: begin
            done    = 1'b1;
            ok      = 1'b0;
            s.phase = PH_IDLE;
          end
        endcase

        // target nack: retry from start without a stop, or give up
        if (nack) begin
          s.attempts = att_n;
          s.byte_idx = 3'd0;
          s.bit_idx  = 3'd0;
          s.phase    = (att_n >= att_limit_i) ? PH_STOP_FAIL : PH_START1;
        end
      end
    end
  end

  assign state_o = s;
  assign latch_o = l;

  assign result_o.scl           = s.scl;
  assign result_o.sda_out       = s.sda;
  assign result_o.busy_res      = (s.phase != PH_IDLE);
  assign result_o.done_res      = done;
  assign result_o.success       = done & ok;
  assign result_o.read_data     = done ? s.read_buf : '0;
  assign result_o.attempts_used = s.attempts;

endmodule

`default_nettype wire

// ===== hdl/i2crm_chk.sv =====
// i2crm_chk: port-level checks on the result channel of the i2c master
// bound to i2c_register_transfer_master, depends on i2crm_pkg
`default_nettype none

module i2crm_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2crm_pkg::out_item_t out_item
);
  import i2crm_pkg::*;

  // finishing item reports the bus as free
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done item still shows busy");

  // status and read data only appear with done
  a_quiet_without_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.done_res |-> !out_item.success && (out_item.read_data == '0))
    else $error("success or read data without done");

  // an idle bus has both lines released
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.busy_res |-> out_item.scl && out_item.sda_out)
    else $error("lines driven low while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

endmodule

bind i2c_register_transfer_master i2crm_chk u_i2crm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== bench/i2c_register_transfer_master_tb.sv =====
// testbench for i2c_register_transfer_master: random-gap driver and checking monitor
// a bus-level predictor, stepped once per accepted item, forms the expected result items
// depends on i2crm_pkg and the i2c_register_transfer_master rtl
`timescale 1ns / 100ps

module i2c_register_transfer_master_tb;
  import i2crm_pkg::*;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   LONG_HOLD   = 300;
  localparam int   ITEM_TARGET = 600;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START, BUS_ADDR_W, BUS_ACK_ADDR_W, BUS_REG, BUS_ACK_REG, BUS_WDATA,
    BUS_ACK_WDATA, BUS_MID_STOP, BUS_RESTART, BUS_ADDR_R, BUS_ACK_ADDR_R, BUS_RDATA,
    BUS_MASTER_ACK, BUS_STOP_OK, BUS_STOP_FAIL
  } bus_phase_e;

  typedef struct packed {
    bus_phase_e  phase;
    logic [1:0]  tick;
    logic [2:0]  bit_idx;
    logic [2:0]  byte_idx;
    logic [7:0]  shift;
    logic [2:0]  tries;
    logic        scl;
    logic        sda;
    logic [55:0] read_buf;
    logic        is_read;
    logic [7:0]  reg_addr;
    logic [2:0]  count;
    logic [55:0] wdata;
  } bus_model_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_item_t   pending_items[$];
  out_item_t  expected_results[$];
  out_item_t  want;
  bus_model_t model_bus;   // follows accepted items
  bus_model_t plan_bus;    // runs ahead while stimulus is generated
  logic [6:0] dev_addr_cfg  = DEV_ADDR_RST;
  logic [2:0] att_limit_cfg = ATT_LIM_RST;

  int idle_level = 1;
  int send_gap = 0;
  int recv_hold = 0;
  int recv_pick;
  int idle_cycles = 0;
  int items_queued = 0;
  int txn_queued = 0;
  int items_sent = 0;
  int results_seen = 0;
  int txn_ok = 0;
  int txn_failed = 0;
  int mismatch_count = 0;
  logic long_hold_done = 1'b0;

  i2c_register_transfer_master u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bus_model_t bus_reset();
    bus_model_t m;
    m = '0;
    m.phase = BUS_IDLE;
    m.scl = 1'b1;
    m.sda = 1'b1;
    return m;
  endfunction

  function automatic void take_nack(inout bus_model_t m, input logic [2:0] lim);
    if (m.tries != 3'd7) m.tries = m.tries + 3'd1;
    m.byte_idx = 3'd0;
    m.bit_idx = 3'd0;
    m.phase = (m.tries >= lim) ? BUS_STOP_FAIL : BUS_START;
  endfunction

  function automatic void load_shift(inout bus_model_t m, input bus_phase_e ph,
                                     input logic [7:0] value);
    m.phase = ph;
    m.shift = value;
    m.bit_idx = 3'd0;
  endfunction

  // one item through the bus sequencer, returns the result item it gives
  function automatic out_item_t bus_step(inout bus_model_t m, input in_item_t it,
                                         input logic [6:0] dev, input logic [2:0] lim);
    out_item_t r;
    logic [1:0] t;
    logic v;
    logic done;
    logic ok;
    done = 1'b0;
    ok = 1'b0;
    if (it.kind == KIND_CMD) begin
      if (m.phase == BUS_IDLE) begin
        m.is_read = it.is_read;
        m.reg_addr = it.reg_addr;
        m.count = (it.byte_count == 3'd0) ? 3'd1 : it.byte_count;
        m.wdata = it.write_data;
        m.phase = BUS_START;
        m.tick = 2'd0;
        m.bit_idx = 3'd0;
        m.byte_idx = 3'd0;
        m.tries = 3'd0;
        m.read_buf = '0;
        m.scl = 1'b1;
        m.sda = 1'b1;
      end
    end else if (m.phase == BUS_IDLE) begin
      m.scl = 1'b1;
      m.sda = 1'b1;
    end else begin
      t = m.tick;
      case (m.phase)
        BUS_START, BUS_RESTART: begin
          m.scl = (t < 2'd2);
          m.sda = (t == 2'd0);
        end
        BUS_MID_STOP, BUS_STOP_OK, BUS_STOP_FAIL: begin
          m.scl = (t >= 2'd1);
          m.sda = (t >= 2'd2);
        end
        default: begin
          v = 1'b1;
          if (m.phase inside {BUS_ADDR_W, BUS_REG, BUS_WDATA, BUS_ADDR_R})
            v = m.shift[7];
          else if (m.phase == BUS_MASTER_ACK)
            v = (int'(m.byte_idx) + 1 >= int'(m.count));  // nack on the last byte
          m.scl = (t == 2'd1);
          m.sda = v;
        end
      endcase

      if (t < 2'd2) begin
        m.tick = t + 2'd1;
      end else begin
        m.tick = 2'd0;
        case (m.phase)
          BUS_START:    load_shift(m, BUS_ADDR_W, {dev, 1'b0});
          BUS_RESTART:  load_shift(m, BUS_ADDR_R, {dev, 1'b1});
          BUS_MID_STOP: m.phase = BUS_RESTART;
          BUS_ADDR_W, BUS_REG, BUS_WDATA, BUS_ADDR_R: begin
            m.shift = {m.shift[6:0], 1'b0};
            if (m.bit_idx == 3'd7) begin
              m.bit_idx = 3'd0;
              case (m.phase)
                BUS_ADDR_W: m.phase = BUS_ACK_ADDR_W;
                BUS_REG:    m.phase = BUS_ACK_REG;
                BUS_WDATA:  m.phase = BUS_ACK_WDATA;
                default:    m.phase = BUS_ACK_ADDR_R;
              endcase
            end else begin
              m.bit_idx = m.bit_idx + 3'd1;
            end
          end
          BUS_ACK_ADDR_W: begin
            if (it.sda_in) take_nack(m, lim);
            else load_shift(m, BUS_REG, m.reg_addr);
          end
          BUS_ACK_REG: begin
            if (it.sda_in) begin
              take_nack(m, lim);
            end else if (m.is_read) begin
              m.phase = BUS_MID_STOP;
            end else begin
              m.byte_idx = 3'd0;
              load_shift(m, BUS_WDATA, m.wdata[7:0]);
            end
          end
          BUS_ACK_WDATA: begin
            if (it.sda_in) begin
              take_nack(m, lim);
            end else begin
              m.byte_idx = m.byte_idx + 3'd1;
              if (m.byte_idx >= m.count) m.phase = BUS_STOP_OK;
              else load_shift(m, BUS_WDATA, m.wdata[8*m.byte_idx +: 8]);
            end
          end
          BUS_ACK_ADDR_R: begin
            if (it.sda_in) begin
              take_nack(m, lim);
            end else begin
              m.byte_idx = 3'd0;
              load_shift(m, BUS_RDATA, 8'h00);
            end
          end
          BUS_RDATA: begin
            m.shift = {m.shift[6:0], it.sda_in};
            if (m.bit_idx == 3'd7) begin
              m.bit_idx = 3'd0;
              if (m.byte_idx < MAX_BYTES)
                m.read_buf[8*m.byte_idx +: 8] = m.read_buf[8*m.byte_idx +: 8] | m.shift;
              m.phase = BUS_MASTER_ACK;
            end else begin
              m.bit_idx = m.bit_idx + 3'd1;
            end
          end
          BUS_MASTER_ACK: begin
            m.byte_idx = m.byte_idx + 3'd1;
            if (m.byte_idx >= m.count) m.phase = BUS_STOP_OK;
            else load_shift(m, BUS_RDATA, 8'h00);
          end
          BUS_STOP_OK: begin
            done = 1'b1;
            ok = 1'b1;
            m.phase = BUS_IDLE;
          end
          default: begin
            done = 1'b1;
            m.phase = BUS_IDLE;
          end
        endcase
      end
    end

    r.scl = m.scl;
    r.sda_out = m.sda;
    r.busy_res = (m.phase != BUS_IDLE);
    r.done_res = done;
    r.success = done & ok;
    r.read_data = done ? m.read_buf : 56'd0;
    r.attempts_used = m.tries;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (idle_level == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_payload();
    in_item_t it;
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    it.kind = KIND_TICK;
    it.is_read = 1'($urandom_range(0, 1));
    it.reg_addr = 8'($urandom_range(0, 255));
    it.byte_count = 3'($urandom_range(0, 7));
    it.write_data = w[55:0];
    it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // tick whose sda level answers the acknowledge sample as planned
  function automatic in_item_t planned_tick(input int nack_pct);
    in_item_t it;
    it = random_payload();
    if (plan_bus.tick == 2'd2 &&
        plan_bus.phase inside {BUS_ACK_ADDR_W, BUS_ACK_REG, BUS_ACK_WDATA, BUS_ACK_ADDR_R})
      it.sda_in = ($urandom_range(0, 99) < nack_pct);
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    out_item_t unused;
    unused = bus_step(plan_bus, it, dev_addr_cfg, att_limit_cfg);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic run_transaction(input logic rd, input logic [7:0] ra, input logic [2:0] cnt,
                                 input logic [55:0] wd, input int nack_pct, input int noise_pct);
    in_item_t it;
    it = random_payload();
    it.kind = KIND_CMD;
    it.is_read = rd;
    it.reg_addr = ra;
    it.byte_count = cnt;
    it.write_data = wd;
    queue_item(it);
    while (plan_bus.phase != BUS_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        // command while busy, should be dropped
        it = random_payload();
        it.kind = KIND_CMD;
        queue_item(it);
      end
      queue_item(planned_tick(nack_pct));
    end
    txn_queued++;
  endtask

  // wait until every queued item is accepted and every result item has come
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEV_ADDR) dev_addr_cfg = val;
    else att_limit_cfg = val[2:0];
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
               $realtime, results_seen, what, got, exp_val);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(bus_step(model_bus, in_item, dev_addr_cfg, att_limit_cfg));
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("item with nothing expected", out_item, 64'd0);
        end else begin
          want = expected_results.pop_front();
          check_field("scl", 64'(out_item.scl), 64'(want.scl));
          check_field("sda_out", 64'(out_item.sda_out), 64'(want.sda_out));
          check_field("busy_res", 64'(out_item.busy_res), 64'(want.busy_res));
          check_field("done_res", 64'(out_item.done_res), 64'(want.done_res));
          check_field("success", 64'(out_item.success), 64'(want.success));
          check_field("read_data", 64'(out_item.read_data), 64'(want.read_data));
          check_field("attempts_used", 64'(out_item.attempts_used),
                      64'(want.attempts_used));
          if (want.done_res && want.success) txn_ok <= txn_ok + 1;
          else if (want.done_res) txn_failed <= txn_failed + 1;
        end
        results_seen <= results_seen + 1;
      end
      if (recv_hold != 0) begin
        out_ready <= 1'b0;
        recv_hold <= recv_hold - 1;
      end else if (!long_hold_done && results_seen > 100 && pending_items.size() > 20) begin
        // long hold so the block backs up and stalls its input
        long_hold_done <= 1'b1;
        out_ready <= 1'b0;
        recv_hold <= LONG_HOLD;
      end else if (out_valid && out_ready) begin
        recv_pick = pick_gap();
        out_ready <= (recv_pick == 0);
        recv_hold <= (recv_pick == 0) ? 0 : recv_pick - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int round;
    int nack_pct;
    int sel;
    logic [2:0] cnt;
    logic [63:0] w;

    model_bus = bus_reset();
    plan_bus = bus_reset();
    round = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle ticks, zero count, one-byte read with stray commands, retries
    queue_item(planned_tick(0));
    queue_item(planned_tick(0));
    run_transaction(1'b0, 8'h00, 3'd0, 56'd0, 0, 0);
    run_transaction(1'b1, 8'hA5, 3'd1, 56'd0, 0, 5);
    run_transaction(1'b0, 8'h3C, 3'd2, 56'h00_0000_0000_C3A5, 100, 0);
    drain();

    // lowest address, a single try
    write_reg(CFG_DEV_ADDR, 7'd0);
    write_reg(CFG_ATT_LIMIT, 7'b1111_001);
    run_transaction(1'b0, 8'h12, 3'd1, 56'h00_0000_0000_0055, 100, 0);
    drain();

    // highest address and try limit
    write_reg(CFG_DEV_ADDR, 7'd127);
    write_reg(CFG_ATT_LIMIT, 7'd7);
    run_transaction(1'b0, 8'h78, 3'd1, 56'h12_3456_789A_BCDE, 20, 0);
    drain();

    // try limit zero acts as a single try
    write_reg(CFG_ATT_LIMIT, 7'b1111_000);
    run_transaction(1'b0, 8'hBC, 3'd1, 56'h00_0000_0000_0011, 100, 0);
    drain();

    // random settings and transactions until the item budget is used
    while (items_queued < ITEM_TARGET) begin
      idle_level = (round % 2 == 0) ? 0 : 1;
      write_reg(CFG_DEV_ADDR, 7'($urandom_range(0, 127)));
      write_reg(CFG_ATT_LIMIT, 7'($urandom_range(0, 127)));
      if ($urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, 3)) queue_item(planned_tick(0));
      sel = $urandom_range(0, 99);
      if (sel < 80) cnt = 3'($urandom_range(1, 2));
      else if (sel < 95) cnt = 3'($urandom_range(3, 6));
      else cnt = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
      sel = $urandom_range(0, 99);
      nack_pct = (sel < 60) ? 0 : (sel < 90) ? 5 : 40;
      w = {$urandom(), $urandom()};
      run_transaction(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), cnt, w[55:0],
                      nack_pct, 1);
      drain();
      round++;
    end

    $display("run covered %0d items in %0d transactions (%0d completed, %0d gave up)",
             items_sent, txn_queued, txn_ok, txn_failed);
    $display("%0d random rounds of settings, long receiver hold %s, %0d mismatches",
             round, long_hold_done ? "done" : "not reached", mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
